>>> rtl/prfi_pkg.sv
// Shared types and constants for the particle radial force integrator.
package prfi_pkg;

    // Item commands
    typedef enum logic [1:0] {
        CMD_REPEL   = 2'd0,
        CMD_ATTRACT = 2'd1,
        CMD_TICK    = 2'd2,
        CMD_PLACE   = 2'd3
    } cmd_t;

    localparam int COORD_BITS_DEF = 24;
    localparam logic [15:0] DAMP_RESET = 16'd32768;

    // Iteration counts of the shared root/divide unit
    localparam int SQRT_STEPS = 32;
    localparam int DIV_QBITS  = 17;

    // Request to the root/divide unit
    typedef struct packed {
        logic        start;
        logic        sqrt_mode;
        logic [63:0] operand;
        logic [31:0] divisor;
    } prfi_req_t;

    // Status from the root/divide unit
    typedef struct packed {
        logic        busy;
        logic        done;
        logic [31:0] result;
    } prfi_rsp_t;

endpackage

>>> rtl/prfi_root_div.sv
// Iterative square root / restoring divider, one result bit per cycle.
module prfi_root_div (
    input  logic                clk,
    input  logic                rst_n,
    input  prfi_pkg::prfi_req_t req,
    output prfi_pkg::prfi_rsp_t rsp
);
    import prfi_pkg::*;

    logic        busy_reg;
    logic        done_reg;
    logic [5:0]  cnt_reg;
    logic        mode_reg;
    logic [63:0] work_reg;
    logic [63:0] root_reg;
    logic [63:0] bit_reg;

    logic [63:0] cand;
    logic [63:0] trial;
    logic [63:0] diff;
    logic        ge;

    // Pick the trial subtraction for the current mode
    always_comb
    begin
        if (mode_reg)
        begin
            cand  = work_reg;
            trial = root_reg + bit_reg;
        end
        else
        begin
            cand  = {31'b0, work_reg[31:0], root_reg[DIV_QBITS-1]};
            trial = {32'b0, bit_reg[31:0]};
        end
        ge   = (cand >= trial);
        diff = cand - trial;
    end

    // Hold control: busy flag, step count and done pulse
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start && !busy_reg)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= req.sqrt_mode ? 6'(SQRT_STEPS - 1) : 6'(DIV_QBITS - 1);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == 6'd0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 6'd1;
                end
            end
        end
    end

    // Load operands, then advance one digit per cycle
    always_ff @(posedge clk)
    begin
        if (req.start && !busy_reg)
        begin
            mode_reg <= req.sqrt_mode;
            if (req.sqrt_mode)
            begin
                work_reg <= req.operand;
                root_reg <= '0;
                bit_reg  <= 64'h4000_0000_0000_0000;
            end
            else
            begin
                work_reg <= req.operand >> DIV_QBITS;
                root_reg <= 64'(req.operand[DIV_QBITS-1:0]);
                bit_reg  <= 64'(req.divisor);
            end
        end
        else if (busy_reg)
        begin
            if (mode_reg)
            begin
                if (ge)
                begin
                    work_reg <= diff;
                    root_reg <= (root_reg >> 1) + bit_reg;
                end
                else
                begin
                    root_reg <= root_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
            end
            else
            begin
                work_reg <= ge ? diff : cand;
                root_reg <= {root_reg[62:0], ge};
            end
        end
    end

    assign rsp.busy   = busy_reg;
    assign rsp.done   = done_reg;
    assign rsp.result = mode_reg ? root_reg[31:0] : 32'(root_reg[DIV_QBITS-1:0]);

endmodule

>>> rtl/particle_radial_force_integrator_unit.sv
// Top level of the particle radial force integrator.
//
//  channel  direction  handshake               payload
//  cfg      in         cfg_wr_en               cfg_wr_data (damping, Q1.15)
//  in       in         in_valid / in_ready     command, point_x/y/z, reach, strength
//  out      out        out_valid / out_ready   pos_x/y/z, force_applied
//
// A force item runs the 32-step square root in the shared root/divide unit and, in
// range, the 17-step divides there: one falloff unless reach is unlimited, and three
// directions.
// One item is in work at a time; in_ready is high only while idle.
// A finished result waits in the output register; the next item is taken meanwhile.
// Reset clears position, velocity and acceleration, and sets damping to 1.0.
module particle_radial_force_integrator_unit #(
    parameter int COORD_BITS = prfi_pkg::COORD_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic        [15:0] cfg_wr_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic        [1:0]  command,
    input  logic signed [23:0] point_x,
    input  logic signed [23:0] point_y,
    input  logic signed [23:0] point_z,
    input  logic        [22:0] reach,
    input  logic signed [15:0] strength,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [23:0] pos_x,
    output logic signed [23:0] pos_y,
    output logic signed [23:0] pos_z,
    output logic               force_applied
);
    import prfi_pkg::*;

    localparam logic signed [34:0] POS_MAX = (35'sd1 <<< (COORD_BITS - 1)) - 35'sd1;
    localparam logic signed [34:0] POS_MIN = -POS_MAX - 35'sd1;
    localparam logic signed [34:0] W32_MAX = 35'sd2147483647;
    localparam logic signed [34:0] W32_MIN = -35'sd2147483648;

    typedef enum logic [4:0] {
        S_IDLE, S_DIFF, S_SQ, S_SUM, S_ROOT_GO, S_ROOT_WAIT, S_PCT_GO, S_PCT_WAIT,
        S_U_GO, S_U_WAIT, S_MUL1, S_MUL2, S_ACCUM, S_T_SUM, S_T_MUL, S_T_DAMP,
        S_T_MOVE, S_PLACE, S_OUT
    } state_t;

    function automatic logic signed [31:0] sat32(input logic signed [34:0] x);
        if (x > W32_MAX) return W32_MAX[31:0];
        if (x < W32_MIN) return W32_MIN[31:0];
        return x[31:0];
    endfunction

    function automatic logic signed [COORD_BITS-1:0] sat_pos(input logic signed [34:0] x);
        if (x > POS_MAX) return POS_MAX[COORD_BITS-1:0];
        if (x < POS_MIN) return POS_MIN[COORD_BITS-1:0];
        return x[COORD_BITS-1:0];
    endfunction

    function automatic logic [23:0] low24(input logic signed [COORD_BITS-1:0] p);
        logic signed [63:0] wide;
        wide = 64'(p);
        return wide[23:0];
    endfunction

    state_t state_reg;
    logic [1:0] ax_reg;
    logic applied_reg;

    logic signed [COORD_BITS-1:0] pos_reg [3];
    logic signed [31:0] vel_reg [3];
    logic signed [31:0] acc_reg [3];
    logic [15:0] damp_reg;

    logic out_valid_reg;
    logic [23:0] pos_x_reg, pos_y_reg, pos_z_reg;
    logic force_applied_reg;

    cmd_t cmd_reg;
    logic signed [23:0] pt_reg [3];
    logic [22:0] reach_reg;
    logic str_neg_reg;
    logic [15:0] str_mag_reg;
    logic [30:0] dmag_reg [3];
    logic dneg_reg [3];
    logic [63:0] sum_reg;
    logic [31:0] dist_reg;
    logic [16:0] pct_reg;
    logic [16:0] u_reg;
    logic [63:0] prod_reg;
    logic [31:0] vmag_reg;
    logic vneg_reg;

    prfi_req_t req;
    prfi_rsp_t rsp;

    logic [32:0] mul_a;
    logic [30:0] mul_b;
    logic [63:0] mul_p;
    logic [30:0] dmag_c [3];
    logic dneg_c [3];
    logic in_range;
    logic [63:0] rnd;
    logic delta_neg;
    logic signed [34:0] delta_s;
    logic signed [31:0] acc_new;
    logic signed [31:0] v_sum;
    logic [63:0] damp_rnd;
    logic signed [34:0] dv_s;
    logic signed [COORD_BITS-1:0] pos_moved;
    logic in_xfer;

    assign in_ready = (state_reg == S_IDLE);
    assign in_xfer  = in_valid && in_ready;

    // Clamp the magnitudes of the three differences to 31 bits
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            logic signed [34:0] dif;
            logic signed [34:0] dabs;
            dif  = 35'(pos_reg[i]) - 35'(pt_reg[i]);
            dabs = dif[34] ? -dif : dif;
            dneg_c[i] = dif[34];
            dmag_c[i] = (dabs > W32_MAX) ? 31'h7FFF_FFFF : dabs[30:0];
        end
    end

    // Share one multiplier between squares, force scaling and damping
    always_comb
    begin
        unique case (state_reg)
            S_SQ:
            begin
                mul_a = 33'(dmag_reg[ax_reg]);
                mul_b = dmag_reg[ax_reg];
            end
            S_MUL1:
            begin
                mul_a = 33'(u_reg);
                mul_b = 31'(str_mag_reg);
            end
            S_MUL2:
            begin
                mul_a = prod_reg[32:0];
                mul_b = 31'(pct_reg);
            end
            S_T_MUL:
            begin
                mul_a = 33'(vmag_reg);
                mul_b = 31'(damp_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_p = 64'(mul_a) * 64'(mul_b);
    end

    // Range test, force step and tick arithmetic
    always_comb
    begin
        in_range  = (rsp.result != 32'd0) &&
                    ((reach_reg == 23'd0) || (rsp.result <= 32'(reach_reg)));
        rnd       = prod_reg + 64'h8000_0000;
        delta_neg = dneg_reg[ax_reg] ^ str_neg_reg ^ (cmd_reg == CMD_ATTRACT);
        delta_s   = delta_neg ? -35'(rnd[48:32]) : 35'(rnd[48:32]);
        acc_new   = sat32(35'(acc_reg[ax_reg]) + delta_s);
        v_sum     = sat32(35'(vel_reg[ax_reg]) + 35'(acc_reg[ax_reg]));
        damp_rnd  = prod_reg + 64'd16384;
        dv_s      = vneg_reg ? -35'(damp_rnd[47:15]) : 35'(damp_rnd[47:15]);
        pos_moved = sat_pos(35'(pos_reg[ax_reg]) + 35'(vel_reg[ax_reg]));
    end

    // Drive the root/divide unit
    always_comb
    begin
        req.start     = (state_reg == S_ROOT_GO) || (state_reg == S_PCT_GO) ||
                        (state_reg == S_U_GO);
        req.sqrt_mode = (state_reg == S_ROOT_GO);
        unique case (state_reg)
            S_ROOT_GO:
            begin
                req.operand = sum_reg;
                req.divisor = '0;
            end
            S_PCT_GO:
            begin
                req.operand = 64'({reach_reg - dist_reg[22:0], 16'b0});
                req.divisor = 32'(reach_reg);
            end
            default:
            begin
                req.operand = 64'({dmag_reg[ax_reg], 16'b0});
                req.divisor = dist_reg;
            end
        endcase
    end

    prfi_root_div u_root_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    // Sequence the item; hold particle state and the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            ax_reg            <= '0;
            applied_reg       <= 1'b0;
            damp_reg          <= DAMP_RESET;
            out_valid_reg     <= 1'b0;
            pos_x_reg         <= '0;
            pos_y_reg         <= '0;
            pos_z_reg         <= '0;
            force_applied_reg <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                pos_reg[i] <= '0;
                vel_reg[i] <= '0;
                acc_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_wr_en)
                damp_reg <= cfg_wr_data;
            if (out_valid_reg && out_ready && (state_reg != S_OUT))
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_xfer)
                    begin
                        ax_reg      <= '0;
                        applied_reg <= 1'b0;
                        unique case (cmd_t'(command))
                            CMD_REPEL, CMD_ATTRACT: state_reg <= S_DIFF;
                            CMD_TICK:               state_reg <= S_T_SUM;
                            CMD_PLACE:              state_reg <= S_PLACE;
                        endcase
                    end
                end
                S_DIFF:
                    state_reg <= S_SQ;
                S_SQ:
                    state_reg <= S_SUM;
                S_SUM:
                begin
                    if (ax_reg == 2'd2)
                        state_reg <= S_ROOT_GO;
                    else
                    begin
                        ax_reg    <= ax_reg + 2'd1;
                        state_reg <= S_SQ;
                    end
                end
                S_ROOT_GO:
                    state_reg <= S_ROOT_WAIT;
                S_ROOT_WAIT:
                begin
                    if (rsp.done)
                    begin
                        ax_reg <= '0;
                        if (!in_range)
                            state_reg <= S_OUT;
                        else if (reach_reg == 23'd0)
                            state_reg <= S_U_GO;
                        else
                            state_reg <= S_PCT_GO;
                    end
                end
                S_PCT_GO:
                    state_reg <= S_PCT_WAIT;
                S_PCT_WAIT:
                begin
                    if (rsp.done)
                        state_reg <= S_U_GO;
                end
                S_U_GO:
                    state_reg <= S_U_WAIT;
                S_U_WAIT:
                begin
                    if (rsp.done)
                        state_reg <= S_MUL1;
                end
                S_MUL1:
                    state_reg <= S_MUL2;
                S_MUL2:
                    state_reg <= S_ACCUM;
                S_ACCUM:
                begin
                    acc_reg[ax_reg] <= acc_new;
                    if (ax_reg == 2'd2)
                    begin
                        applied_reg <= 1'b1;
                        state_reg   <= S_OUT;
                    end
                    else
                    begin
                        ax_reg    <= ax_reg + 2'd1;
                        state_reg <= S_U_GO;
                    end
                end
                S_T_SUM:
                    state_reg <= S_T_MUL;
                S_T_MUL:
                    state_reg <= S_T_DAMP;
                S_T_DAMP:
                begin
                    vel_reg[ax_reg] <= sat32(dv_s);
                    state_reg       <= S_T_MOVE;
                end
                S_T_MOVE:
                begin
                    pos_reg[ax_reg] <= pos_moved;
                    acc_reg[ax_reg] <= '0;
                    if (ax_reg == 2'd2)
                        state_reg <= S_OUT;
                    else
                    begin
                        ax_reg    <= ax_reg + 2'd1;
                        state_reg <= S_T_SUM;
                    end
                end
                S_PLACE:
                begin
                    for (int i = 0; i < 3; i++)
                        pos_reg[i] <= sat_pos(35'(pt_reg[i]));
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg     <= 1'b1;
                        pos_x_reg         <= low24(pos_reg[0]);
                        pos_y_reg         <= low24(pos_reg[1]);
                        pos_z_reg         <= low24(pos_reg[2]);
                        force_applied_reg <= applied_reg;
                        state_reg         <= S_IDLE;
                    end
                    else if (out_valid_reg && out_ready)
                        out_valid_reg <= 1'b0;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    // Capture the item and the working values of each step
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            cmd_reg     <= cmd_t'(command);
            pt_reg[0]   <= point_x;
            pt_reg[1]   <= point_y;
            pt_reg[2]   <= point_z;
            reach_reg   <= reach;
            str_neg_reg <= strength[15];
            str_mag_reg <= strength[15] ? 16'(-strength) : 16'(strength);
            sum_reg     <= '0;
        end
        unique case (state_reg)
            S_DIFF:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    dmag_reg[i] <= dmag_c[i];
                    dneg_reg[i] <= dneg_c[i];
                end
            end
            S_SQ, S_MUL1, S_MUL2, S_T_MUL:
                prod_reg <= mul_p;
            S_SUM:
                sum_reg <= sum_reg + prod_reg;
            S_ROOT_WAIT:
            begin
                if (rsp.done)
                begin
                    dist_reg <= rsp.result;
                    pct_reg  <= 17'h1_0000;
                end
            end
            S_PCT_WAIT:
            begin
                if (rsp.done)
                    pct_reg <= rsp.result[16:0];
            end
            S_U_WAIT:
            begin
                if (rsp.done)
                    u_reg <= rsp.result[16:0];
            end
            S_T_SUM:
            begin
                vneg_reg <= v_sum[31];
                vmag_reg <= v_sum[31] ? (~v_sum + 32'd1) : v_sum;
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid     = out_valid_reg;
    assign pos_x         = pos_x_reg;
    assign pos_y         = pos_y_reg;
    assign pos_z         = pos_z_reg;
    assign force_applied = force_applied_reg;

`ifndef SYNTH
    // The shared unit runs only while the sequencer waits on it
    a_unit_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !rsp.busy)
        else $error("root/divide unit busy while idle");

    // A finished result arrives only in a waiting state
    a_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.done |-> (state_reg == S_ROOT_WAIT || state_reg == S_PCT_WAIT ||
                      state_reg == S_U_WAIT))
        else $error("unit result with no step waiting");

    // An accepted item drops ready for its work
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> !in_ready)
        else $error("second item taken while one is in work");

    // The unit is started only when free
    a_start_free: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> !rsp.busy)
        else $error("unit started while busy");
`endif

endmodule
